>>> rtl/tcbw_pkg.sv
package tcbw_pkg;

  // Store geometry.
  localparam int MAX_CELLS = 8192;
  localparam int CELL_AW   = $clog2(MAX_CELLS);
  localparam int TOT_W     = CELL_AW + 1;
  localparam int PROD_W    = 15;
  localparam int CMP_W     = (TOT_W > PROD_W) ? TOT_W : PROD_W;

  // Field and register widths.
  localparam int MODE_W   = 2;
  localparam int CODE_W   = 16;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int CURSOR_W = 13;
  localparam int COLS_W   = 8;
  localparam int ROWS_W   = 7;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 8;

  // Remainder unit widths.
  localparam int REM_W   = COLS_W;
  localparam int DIVC_W  = $clog2(CELL_AW + 1);

  // Register reset values.
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(24);

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_ROWS    = 1'b1;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLACE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SETCUR = 2'd3;

  // Character code classes.
  localparam logic [CODE_W-1:0] CODE_NEWLINE  = CODE_W'(10);
  localparam logic [CODE_W-1:0] CODE_SPACE    = CODE_W'(32);
  localparam logic [CODE_W-1:0] CODE_PRINT_LO = CODE_W'(32);
  localparam logic [CODE_W-1:0] CODE_PRINT_HI = CODE_W'(126);
  localparam logic [CODE_W-1:0] CODE_GLYPH_LO = CODE_W'(10000);
  localparam logic [CODE_W-1:0] CODE_GLYPH_HI = CODE_W'(20000);

  // Request to the remainder unit.
  typedef struct packed {
    logic               start;
    logic [CELL_AW-1:0] dividend;
    logic [REM_W-1:0]   divisor;
  } tcbw_div_req_t;

endpackage

>>> rtl/tcbw_ram.sv
module tcbw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/tcbw_rem_unit.sv
module tcbw_rem_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcbw_pkg::tcbw_div_req_t     req,
  output logic                        done,
  output logic [tcbw_pkg::REM_W-1:0]  rem
);

  import tcbw_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [DIVC_W-1:0]  cnt_r;
  logic [CELL_AW-1:0] dvd_r;
  logic [REM_W-1:0]   dvs_r;
  logic [REM_W-1:0]   rem_r;
  logic [REM_W:0]     trial;
  logic [REM_W-1:0]   rem_nxt;

  // One quotient bit per cycle: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_r, dvd_r[CELL_AW-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = REM_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = REM_W'(trial);
    end
  end

  // Iteration control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == DIVC_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIVC_W'(CELL_AW);
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[CELL_AW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIVC_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> rtl/text_cell_buffer_writer_unit.sv
// Each item passes through S_GEOM and S_ADDR, then S_READ for a read or S_DIV for a
// newline, whose column remainder comes from a one-bit-per-cycle remainder unit, and
// then S_DONE, which holds while the output register is full and not taken. One item
// is in flight at a time; the next beat is taken while the result waits.
// Reset is synchronous: a clearing pass zeroes all MAX_CELLS (8192) cells of the store,
// during which no input beat is taken; configuration writes are taken throughout.
module text_cell_buffer_writer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcbw_pkg::MODE_W-1:0]   in_mode,
  input  logic [tcbw_pkg::CODE_W-1:0]   in_char_code,
  input  logic [tcbw_pkg::COL_W-1:0]    in_col,
  input  logic [tcbw_pkg::ROW_W-1:0]    in_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcbw_pkg::CODE_W-1:0]   out_cell_code,
  output logic [tcbw_pkg::CURSOR_W-1:0] out_cursor_pos,
  input  logic                          cfg_we,
  input  logic [tcbw_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [tcbw_pkg::CFG_DW-1:0]   cfg_wdata
);

  import tcbw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_GEOM,
    S_ADDR,
    S_READ,
    S_DIV,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [CELL_AW-1:0]  clr_cnt_r;
  logic [COLS_W-1:0]   columns_r;
  logic [ROWS_W-1:0]   rows_r;
  logic [CELL_AW-1:0]  cursor_r;
  logic [MODE_W-1:0]   mode_r;
  logic [CODE_W-1:0]   code_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [TOT_W-1:0]    total_r;
  logic [PROD_W-1:0]   lin_r;
  logic [CELL_AW-1:0]  pos_r;
  logic [CODE_W-1:0]   cell_r;
  logic                out_valid_r;
  logic [CODE_W-1:0]   out_cell_code_r;
  logic [CURSOR_W-1:0] out_cursor_pos_r;

  logic [COLS_W-1:0]   eff_cols;
  logic [ROWS_W-1:0]   eff_rows;
  logic [PROD_W-1:0]   prod;
  logic [TOT_W-1:0]    total_nxt;
  logic [PROD_W-1:0]   lin_nxt;
  logic [CELL_AW-1:0]  last_cell;
  logic [CELL_AW-1:0]  cur_clamp;
  logic [CELL_AW-1:0]  addr_clamp;
  logic [CELL_AW-1:0]  wr_pos;
  logic [CELL_AW-1:0]  step_pos;
  logic [CMP_W-1:0]    step_sum;
  logic [CMP_W-1:0]    line_sum;
  logic [CELL_AW-1:0]  line_pos;
  logic                code_keep;
  logic                code_nl;
  logic [CODE_W-1:0]   store_code;

  logic                ram_we;
  logic [CELL_AW-1:0]  ram_addr;
  logic [CODE_W-1:0]   ram_wdata;
  logic [CODE_W-1:0]   ram_rdata;

  tcbw_div_req_t       div_req;
  logic                div_done;
  logic [REM_W-1:0]    div_rem;

  // Effective geometry: a zero register counts as one.
  always_comb begin
    eff_cols  = (columns_r == '0) ? COLS_W'(1) : columns_r;
    eff_rows  = (rows_r == '0) ? ROWS_W'(1) : rows_r;
    prod      = PROD_W'(eff_cols) * PROD_W'(eff_rows);
    total_nxt = (CMP_W'(prod) > CMP_W'(MAX_CELLS)) ? TOT_W'(MAX_CELLS) : TOT_W'(prod);
    lin_nxt   = PROD_W'(PROD_W'(row_r) * PROD_W'(eff_cols)) + PROD_W'(col_r);
  end

  // Clamped cursor and addressed cell.
  always_comb begin
    last_cell  = CELL_AW'(total_r - 1'b1);
    cur_clamp  = (CMP_W'(cursor_r) >= CMP_W'(total_r)) ? last_cell : cursor_r;
    addr_clamp = (CMP_W'(lin_r) >= CMP_W'(total_r)) ? last_cell : CELL_AW'(lin_r);
    wr_pos     = (mode_r == MODE_PLACE) ? addr_clamp : cur_clamp;
    step_sum   = CMP_W'(wr_pos) + CMP_W'(1);
    step_pos   = (step_sum >= CMP_W'(total_r)) ? last_cell : CELL_AW'(step_sum);
    line_sum   = CMP_W'(pos_r) - CMP_W'(div_rem) + CMP_W'(eff_cols);
    line_pos   = (line_sum >= CMP_W'(total_r)) ? last_cell : CELL_AW'(line_sum);
  end

  // Code classification for writes.
  always_comb begin
    code_keep  = ((code_r >= CODE_PRINT_LO) && (code_r <= CODE_PRINT_HI)) ||
                 ((code_r >= CODE_GLYPH_LO) && (code_r <= CODE_GLYPH_HI));
    code_nl    = (code_r == CODE_NEWLINE);
    store_code = code_keep ? code_r : CODE_SPACE;
  end

  // Memory port: clearing sweep, cell write or cell read.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_clamp;
    ram_wdata = store_code;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == S_ADDR) begin
      if ((mode_r == MODE_PUT) || (mode_r == MODE_PLACE)) begin
        ram_we   = !code_nl;
        ram_addr = wr_pos;
      end
    end
  end

  // Newline requests the column remainder of the write position.
  always_comb begin
    div_req.start    = (state_r == S_ADDR) && code_nl &&
                       ((mode_r == MODE_PUT) || (mode_r == MODE_PLACE));
    div_req.dividend = wr_pos;
    div_req.divisor  = eff_cols;
  end

  tcbw_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  tcbw_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign in_ready = (state_r == S_IDLE);

  // Item sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      columns_r   <= COLS_RESET;
      rows_r      <= ROWS_RESET;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLUMNS: columns_r <= cfg_wdata;
          CFG_ROWS:    rows_r    <= ROWS_W'(cfg_wdata);
          default:     ;
        endcase
      end

      // The output register empties when its beat is taken and nothing replaces it.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CELL_AW'(MAX_CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            code_r  <= in_char_code;
            col_r   <= in_col;
            row_r   <= in_row;
            state_r <= S_GEOM;
          end
        end
        S_GEOM: begin
          total_r <= total_nxt;
          lin_r   <= lin_nxt;
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          cell_r <= '0;
          unique case (mode_r) inside
            MODE_PUT, MODE_PLACE: begin
              pos_r <= wr_pos;
              if (code_nl) begin
                state_r <= S_DIV;
              end else begin
                cursor_r <= step_pos;
                state_r  <= S_DONE;
              end
            end
            MODE_READ: begin
              cursor_r <= cur_clamp;
              state_r  <= S_READ;
            end
            MODE_SETCUR: begin
              cursor_r <= addr_clamp;
              state_r  <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_READ: begin
          cell_r  <= ram_rdata;
          state_r <= S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            cursor_r <= line_pos;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r      <= 1'b1;
            out_cell_code_r  <= cell_r;
            out_cursor_pos_r <= CURSOR_W'(cursor_r);
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_code  = out_cell_code_r;
  assign out_cursor_pos = out_cursor_pos_r;

endmodule

>>> bench/tcbw_result_checker.sv
module tcbw_result_checker
  import tcbw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [CODE_W-1:0]   in_char_code,
  input  logic [COL_W-1:0]    in_col,
  input  logic [ROW_W-1:0]    in_row,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [CODE_W-1:0]   out_cell_code,
  input  logic [CURSOR_W-1:0] out_cursor_pos,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  output int                  fail_count,
  output int                  pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CODE_W-1:0]   cell_code;
    logic [CURSOR_W-1:0] cursor_pos;
  } cell_result_t;

  // Shadow copy of the screen, the cursor and the geometry registers.
  logic [CODE_W-1:0] screen_cells [MAX_CELLS];
  int unsigned       cursor_at;
  int unsigned       line_cols;
  int unsigned       line_rows;
  cell_result_t      expected_cells [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  // A zero register counts as one line or one column.
  function automatic int unsigned line_width();
    return (line_cols == 0) ? 1 : line_cols;
  endfunction

  // Usable cells saturate at the size of the store.
  function automatic int unsigned usable_cells();
    int unsigned height;
    int unsigned total;
    height = (line_rows == 0) ? 1 : line_rows;
    total  = line_width() * height;
    return (total > MAX_CELLS) ? MAX_CELLS : total;
  endfunction

  function automatic int unsigned clamp_cell(input int unsigned pos);
    int unsigned total;
    total = usable_cells();
    return (pos >= total) ? total - 1 : pos;
  endfunction

  // The column is not checked against the line width; only the sum is clamped.
  function automatic int unsigned grid_addr(input int unsigned c, input int unsigned r);
    return clamp_cell(r * line_width() + c);
  endfunction

  // Stores a code at the cursor (or moves to the next line) and advances.
  task automatic put_code(input logic [CODE_W-1:0] code);
    int unsigned w;
    w = line_width();
    if ((code >= CODE_PRINT_LO && code <= CODE_PRINT_HI) ||
        (code >= CODE_GLYPH_LO && code <= CODE_GLYPH_HI)) begin
      screen_cells[cursor_at] = code;
    end else if (code == CODE_NEWLINE) begin
      cursor_at = clamp_cell(cursor_at + (w - (cursor_at % w) - 1));
    end else begin
      screen_cells[cursor_at] = CODE_SPACE;
    end
    cursor_at = clamp_cell(cursor_at + 1);
  endtask

  // Applies one input beat to the shadow state and returns the result it causes.
  task automatic apply_text_item(input logic [MODE_W-1:0] mode,
                                 input logic [CODE_W-1:0] code,
                                 input logic [COL_W-1:0]  col,
                                 input logic [ROW_W-1:0]  row,
                                 output cell_result_t     res);
    logic [CODE_W-1:0] read_code;
    read_code = '0;
    // The geometry may have shrunk under the cursor since the last item.
    cursor_at = clamp_cell(cursor_at);
    case (mode)
      MODE_PUT: begin
        put_code(code);
      end
      MODE_PLACE: begin
        cursor_at = grid_addr(col, row);
        put_code(code);
      end
      MODE_READ: begin
        read_code = screen_cells[grid_addr(col, row)];
      end
      MODE_SETCUR: begin
        cursor_at = grid_addr(col, row);
      end
      default: begin
      end
    endcase
    res.cell_code  = read_code;
    res.cursor_pos = CURSOR_W'(cursor_at);
  endtask

  // Watch all three ports on every edge.
  always @(posedge clk) begin
    cell_result_t want;
    cell_result_t next_res;
    if (!rst_n) begin
      for (int i = 0; i < MAX_CELLS; i++) begin
        screen_cells[i] = '0;
      end
      cursor_at = 0;
      line_cols = COLS_RESET;
      line_rows = ROWS_RESET;
      expected_cells.delete();
    end else begin
      // Result beats are checked against the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result beat with nothing pending: cell_code=%0d cursor_pos=%0d",
                     $realtime, out_cell_code, out_cursor_pos);
          end
        end else begin
          want = expected_cells.pop_front();
          if (out_cell_code !== want.cell_code || out_cursor_pos !== want.cursor_pos) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: cell_code exp %0d got %0d, cursor_pos exp %0d got %0d",
                       $realtime, want.cell_code, out_cell_code,
                       want.cursor_pos, out_cursor_pos);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_text_item(in_mode, in_char_code, in_col, in_row, next_res);
        expected_cells.push_back(next_res);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_COLUMNS) begin
          line_cols = cfg_wdata;
        end else if (cfg_index == CFG_ROWS) begin
          line_rows = cfg_wdata[ROWS_W-1:0];
        end
      end
    end
    pending_results = expected_cells.size();
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  import tcbw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          PHASES       = 10;
  localparam int          PHASE_ITEMS  = 200;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode        = '0;
  logic [CODE_W-1:0]   in_char_code   = '0;
  logic [COL_W-1:0]    in_col         = '0;
  logic [ROW_W-1:0]    in_row         = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [CODE_W-1:0]   out_cell_code;
  logic [CURSOR_W-1:0] out_cursor_pos;
  logic                cfg_we         = 1'b0;
  logic [CFG_IW-1:0]   cfg_index      = '0;
  logic [CFG_DW-1:0]   cfg_wdata      = '0;

  int          fail_count;
  int          pending_results;
  int unsigned cycle_count = 0;
  int unsigned geo_cols    = COLS_RESET;
  int unsigned geo_rows    = ROWS_RESET;
  int unsigned stall_kind  = 0;
  int unsigned stall_left  = 0;

  text_cell_buffer_writer_unit DUT (.*);

  tcbw_result_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver switches between always ready, coin-flip stalls and long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_kind <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_kind <= $urandom_range(0, 2);
        stall_left <= $urandom_range(32, 256);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_kind)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Presents one beat and holds it until the block takes it.
  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [CODE_W-1:0] code,
                           input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_char_code <= code;
    in_col       <= col;
    in_row       <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops sending and waits for every predicted result to come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Writes both geometry registers on consecutive edges.
  task automatic set_geometry(input int unsigned cols, input int unsigned rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLUMNS;
    cfg_wdata <= CFG_DW'(cols);
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= CFG_DW'(rows);
    @(posedge clk);
    cfg_we    <= 1'b0;
    geo_cols = cols & 32'hFF;
    geo_rows = rows & 32'h7F;
  endtask

  // Random item, mostly addressed inside the current grid so that reads find text.
  task automatic pick_item(output logic [MODE_W-1:0] mode, output logic [CODE_W-1:0] code,
                           output logic [COL_W-1:0] col, output logic [ROW_W-1:0] row);
    int unsigned pick;
    int unsigned col_span;
    int unsigned row_span;
    pick = $urandom_range(0, 99);
    if (pick < 45)      mode = MODE_PUT;
    else if (pick < 60) mode = MODE_PLACE;
    else if (pick < 82) mode = MODE_READ;
    else                mode = MODE_SETCUR;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      code = CODE_W'($urandom_range(CODE_PRINT_LO, CODE_PRINT_HI));
    end else if (pick < 55) begin
      code = CODE_W'($urandom_range(CODE_GLYPH_LO, CODE_GLYPH_HI));
    end else if (pick < 68) begin
      code = CODE_NEWLINE;
    end else if (pick < 78) begin
      case ($urandom_range(0, 5))
        0: code = CODE_W'(CODE_PRINT_LO - 1);
        1: code = CODE_W'(CODE_PRINT_HI + 1);
        2: code = CODE_W'(CODE_GLYPH_LO - 1);
        3: code = CODE_W'(CODE_GLYPH_HI + 1);
        4: code = '0;
        default: code = '1;
      endcase
    end else begin
      code = CODE_W'($urandom_range(0, 65535));
    end
    col_span = (geo_cols == 0) ? 1 : ((geo_cols > 128) ? 128 : geo_cols);
    row_span = (geo_rows == 0) ? 1 : ((geo_rows > 64) ? 64 : geo_rows);
    if ($urandom_range(0, 3) != 0) begin
      col = COL_W'($urandom_range(0, col_span - 1));
      row = ROW_W'($urandom_range(0, row_span - 1));
    end else begin
      col = COL_W'($urandom_range(0, 127));
      row = ROW_W'($urandom_range(0, 63));
    end
  endtask

  initial begin
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    int                sent;
    int                burst;
    int                gap;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every code class at the reset geometry of 80 by 24.
    send_beat(MODE_PUT, 16'd65, 0, 0);
    send_beat(MODE_PUT, CODE_W'(CODE_PRINT_LO - 1), 0, 0);
    send_beat(MODE_PUT, CODE_PRINT_HI, 0, 0);
    send_beat(MODE_PUT, CODE_W'(CODE_PRINT_HI + 1), 0, 0);
    send_beat(MODE_PUT, CODE_W'(CODE_GLYPH_LO - 1), 0, 0);
    send_beat(MODE_PUT, CODE_GLYPH_LO, 0, 0);
    send_beat(MODE_PUT, CODE_GLYPH_HI, 0, 0);
    send_beat(MODE_PUT, CODE_W'(CODE_GLYPH_HI + 1), 0, 0);
    send_beat(MODE_PUT, '0, 0, 0);
    send_beat(MODE_PUT, '1, 0, 0);
    send_beat(MODE_PUT, CODE_NEWLINE, 0, 0);
    // Address past the last cell, then a write there keeps the cursor on it.
    send_beat(MODE_PLACE, 16'd90, 127, 63);
    send_beat(MODE_READ, '0, 127, 63);
    send_beat(MODE_READ, '0, 0, 0);
    // Newline from the last column of a line.
    send_beat(MODE_SETCUR, '0, 79, 0);
    send_beat(MODE_PUT, CODE_NEWLINE, 0, 0);
    // Column beyond the line width wraps into the next line.
    send_beat(MODE_PLACE, 16'd99, 100, 0);
    send_beat(MODE_READ, '1, 20, 1);

    // Zero geometry means a single cell, and the cursor shrinks onto it.
    wait_idle();
    set_geometry(0, 0);
    send_beat(MODE_PUT, 16'd113, 0, 0);
    send_beat(MODE_PUT, CODE_NEWLINE, 0, 0);
    send_beat(MODE_READ, '0, 127, 63);

    // Oversize geometry saturates at the store size.
    wait_idle();
    set_geometry(255, 127);
    send_beat(MODE_SETCUR, '0, 127, 63);
    send_beat(MODE_PUT, 16'd120, 0, 0);
    send_beat(MODE_PLACE, CODE_GLYPH_LO, 5, 1);
    send_beat(MODE_READ, '0, 127, 63);

    // Random phases, each under its own geometry.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_geometry(1, 1);
        1: set_geometry(128, 64);
        2: set_geometry(255, 127);
        3: set_geometry(0, 9);
        4: set_geometry(12, 0);
        5: set_geometry(80, 24);
        default: begin
          if ($urandom_range(0, 9) < 6) begin
            set_geometry($urandom_range(1, 16), $urandom_range(1, 8));
          end else begin
            set_geometry($urandom_range(0, 255), $urandom_range(0, 255));
          end
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          pick_item(mode, code, col, row);
          send_beat(mode, code, col, row);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // Drain, then leave room for any stray result beat.
    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
